FILE: src/cts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cts_pkg
// Shared types and constants for the contact threshold search block.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int MAX_NODES_DEF = 8;
  localparam int COORD_W       = 25;
  localparam int THR_W         = 6;
  localparam int ABS_W         = COORD_W + 1;
  localparam int SQ_W          = 2 * ABS_W;
  localparam int MILLI_W       = 16;
  localparam int LIMIT_W       = 2 * MILLI_W;

  localparam logic [THR_W-1:0]   AUTO_FIRST = 6'd7;
  localparam logic [THR_W-1:0]   AUTO_LAST  = 6'd15;
  localparam logic [MILLI_W-1:0] MILLI      = 16'd1000;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WAIT1,
    S_WAIT2,
    S_SWEEP,
    S_DRAIN,
    S_CLOSE,
    S_DECIDE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_thr;
    logic inc_thr;
    logic clear_adj;
    logic pair_valid;
    logic init_reach;
    logic close_valid;
    logic finish;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic graph_ok;
    logic auto_mode;
    logic thr_last;
  } stat_t;

endpackage

`default_nettype wire

FILE: src/cts_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cts_datapath
// Coordinate store, pairwise distance pipeline, adjacency, reachability.
// ----------------------------------------------------------------------------
module cts_datapath #(
  parameter int MAX_NODES = cts_pkg::MAX_NODES_DEF,
  parameter int IDX_W     = $clog2(MAX_NODES),
  parameter int CNT_W     = $clog2(MAX_NODES + 1)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          load,
  input  wire logic signed [cts_pkg::COORD_W-1:0] x_coord,
  input  wire logic signed [cts_pkg::COORD_W-1:0] y_coord,
  input  wire logic signed [cts_pkg::COORD_W-1:0] z_coord,
  input  wire logic                          cfg_we,
  input  wire logic [cts_pkg::THR_W-1:0]     cfg_wdata,
  input  wire cts_pkg::cmd_t                 cmd,
  input  wire logic [IDX_W-1:0]              pair_a,
  input  wire logic [IDX_W-1:0]              pair_b,
  input  wire logic [IDX_W-1:0]              close_node,
  output cts_pkg::stat_t                     stat,
  output logic [CNT_W-1:0]                   count,
  output logic [cts_pkg::THR_W-1:0]          chosen_threshold,
  output logic                               connected,
  output logic                               too_many,
  output logic                               done
);
  import cts_pkg::*;

  logic signed [COORD_W-1:0] x_mem [MAX_NODES];
  logic signed [COORD_W-1:0] y_mem [MAX_NODES];
  logic signed [COORD_W-1:0] z_mem [MAX_NODES];

  logic [THR_W-1:0]   manual;
  logic [THR_W-1:0]   thr;
  logic [MILLI_W-1:0] t_milli;
  logic [LIMIT_W-1:0] limit;
  logic               overflow;

  logic signed [COORD_W-1:0] xa, ya, za, xb, yb, zb;
  logic                      v1, v2, v3;
  logic [IDX_W-1:0]          a1, b1, a2, b2, a3, b3;
  logic [ABS_W-1:0]          ax, ay, az;
  logic [SQ_W-1:0]           sx, sy, sz;
  logic [SQ_W-1:0]           d2;
  logic                      contact;

  logic signed [ABS_W-1:0] dx, dy, dz;
  logic [MAX_NODES-1:0]    adj [MAX_NODES];
  logic [MAX_NODES-1:0]    reached;
  logic [MAX_NODES-1:0]    all_mask;
  logic                    full;

  assign full = (count == CNT_W'(MAX_NODES));

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      manual <= '0;
    end else if (cfg_we) begin
      manual <= cfg_wdata;
    end
  end

  // node count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (cmd.finish) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (load) begin
      if (full) begin
        overflow <= 1'b1;
      end else begin
        count <= count + CNT_W'(1);
      end
    end
  end

  // coordinate store, two registered read ports
  always_ff @(posedge clk) begin
    if (load && !full) begin
      x_mem[count[IDX_W-1:0]] <= x_coord;
      y_mem[count[IDX_W-1:0]] <= y_coord;
      z_mem[count[IDX_W-1:0]] <= z_coord;
    end
    xa <= x_mem[pair_a];
    ya <= y_mem[pair_a];
    za <= z_mem[pair_a];
    xb <= x_mem[pair_b];
    yb <= y_mem[pair_b];
    zb <= z_mem[pair_b];
  end

  // threshold and squared limit in millionths
  always_ff @(posedge clk) begin
    if (cmd.load_thr) begin
      thr <= (manual != '0) ? manual : AUTO_FIRST;
    end else if (cmd.inc_thr) begin
      thr <= thr + THR_W'(1);
    end
    t_milli <= MILLI_W'(thr * MILLI);
    limit   <= t_milli * t_milli;
  end

  // distance pipeline valid and index tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.pair_valid;
      v2 <= v1;
      v3 <= v2;
    end
    a1 <= pair_a;
    b1 <= pair_b;
    a2 <= a1;
    b2 <= b1;
    a3 <= a2;
    b3 <= b2;
  end

  // differences and absolute values
  assign dx = {xa[COORD_W-1], xa} - {xb[COORD_W-1], xb};
  assign dy = {ya[COORD_W-1], ya} - {yb[COORD_W-1], yb};
  assign dz = {za[COORD_W-1], za} - {zb[COORD_W-1], zb};

  always_ff @(posedge clk) begin
    ax <= dx[ABS_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
    ay <= dy[ABS_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
    az <= dz[ABS_W-1] ? ABS_W'(-dz) : ABS_W'(dz);
    sx <= ax * ax;
    sy <= ay * ay;
    sz <= az * az;
  end

  // sum and compare against the limit
  assign d2      = sx + sy + sz;
  assign contact = (d2 != '0) && (d2 < SQ_W'(limit));

  // adjacency matrix
  always_ff @(posedge clk) begin
    if (cmd.clear_adj) begin
      for (int k = 0; k < MAX_NODES; k++) begin
        adj[k] <= '0;
      end
    end else if (v3 && contact) begin
      adj[a3][b3] <= 1'b1;
    end
  end

  // reachability closure, one node per cycle
  always_ff @(posedge clk) begin
    if (cmd.init_reach) begin
      reached <= MAX_NODES'(1);
    end else if (cmd.close_valid && reached[close_node]) begin
      reached <= reached | adj[close_node];
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_NODES; k++) begin
      all_mask[k] = (CNT_W'(k) < count);
    end
  end

  assign stat.pipe_busy = v1 | v2 | v3;
  assign stat.graph_ok  = (count <= CNT_W'(1)) || (reached == all_mask);
  assign stat.auto_mode = (manual == '0);
  assign stat.thr_last  = (thr == AUTO_LAST);

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
    if (cmd.finish) begin
      chosen_threshold <= thr;
      connected        <= stat.graph_ok;
      too_many         <= overflow;
    end
  end

  // no transfer stored beyond capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_NODES))
    else $error("node count above capacity");

  // result strobe lasts one cycle
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held");

  // set is cleared after a result
  a_clear_after: assert property (@(posedge clk) disable iff (rst)
    done |-> (count == '0 || $past(load)))
    else $error("set not cleared after result");

endmodule

`default_nettype wire

FILE: src/cts_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cts_ctrl
// Sequencer for pair sweep, closure passes and threshold search.
// ----------------------------------------------------------------------------
module cts_ctrl #(
  parameter int MAX_NODES = cts_pkg::MAX_NODES_DEF,
  parameter int IDX_W     = $clog2(MAX_NODES),
  parameter int CNT_W     = $clog2(MAX_NODES + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic             last_residue,
  input  wire cts_pkg::stat_t   stat,
  input  wire logic [CNT_W-1:0] count,
  output logic                  busy,
  output cts_pkg::cmd_t         cmd,
  output logic [IDX_W-1:0]      pair_a,
  output logic [IDX_W-1:0]      pair_b,
  output logic [IDX_W-1:0]      close_node
);
  import cts_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] ci, ci_next, cj, cj_next;
  logic [CNT_W-1:0] pass, pass_next;
  logic             ci_end, cj_end, pass_end;

  assign ci_end   = (CNT_W'(ci) + CNT_W'(1)) == count;
  assign cj_end   = (CNT_W'(cj) + CNT_W'(1)) == count;
  assign pass_end = (pass + CNT_W'(2)) >= count;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ci    <= '0;
      cj    <= '0;
      pass  <= '0;
    end else begin
      state <= state_next;
      ci    <= ci_next;
      cj    <= cj_next;
      pass  <= pass_next;
    end
  end

  always_comb begin
    state_next = state;
    ci_next    = ci;
    cj_next    = cj;
    pass_next  = pass;
    cmd        = '0;
    busy       = (state != S_IDLE);
    pair_a     = ci;
    pair_b     = cj;
    close_node = ci;
    unique case (state)
      S_IDLE: begin
        if (start && last_residue) begin
          cmd.load_thr  = 1'b1;
          cmd.clear_adj = 1'b1;
          state_next    = S_WAIT1;
        end
      end
      S_WAIT1: begin
        state_next = S_WAIT2;
      end
      S_WAIT2: begin
        ci_next = '0;
        cj_next = '0;
        if (count <= CNT_W'(1)) begin
          state_next = S_DECIDE;
        end else begin
          state_next = S_SWEEP;
        end
      end
      S_SWEEP: begin
        cmd.pair_valid = 1'b1;
        if (cj_end) begin
          cj_next = '0;
          if (ci_end) begin
            ci_next    = '0;
            state_next = S_DRAIN;
          end else begin
            ci_next = ci + IDX_W'(1);
          end
        end else begin
          cj_next = cj + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (!stat.pipe_busy) begin
          cmd.init_reach = 1'b1;
          ci_next        = '0;
          pass_next      = '0;
          state_next     = S_CLOSE;
        end
      end
      S_CLOSE: begin
        cmd.close_valid = 1'b1;
        if (ci_end) begin
          ci_next = '0;
          if (pass_end) begin
            state_next = S_DECIDE;
          end else begin
            pass_next = pass + CNT_W'(1);
          end
        end else begin
          ci_next = ci + IDX_W'(1);
        end
      end
      S_DECIDE: begin
        if (!stat.auto_mode || stat.graph_ok || stat.thr_last) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.inc_thr   = 1'b1;
          cmd.clear_adj = 1'b1;
          state_next    = S_WAIT1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // finishing always returns to idle
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == S_IDLE)
    else $error("finish without return to idle");

  // pairs issued only for stored nodes
  a_pair_range: assert property (@(posedge clk) disable iff (rst)
    cmd.pair_valid |-> (CNT_W'(pair_a) < count) && (CNT_W'(pair_b) < count))
    else $error("pair index beyond node count");

  // closure starts only with the distance pipeline empty
  a_close_drained: assert property (@(posedge clk) disable iff (rst)
    cmd.close_valid |-> !stat.pipe_busy)
    else $error("closure while pipeline busy");

endmodule

`default_nettype wire

FILE: src/contact_threshold_search.sv
`default_nettype none
// ----------------------------------------------------------------------------
// contact_threshold_search
// Finds the smallest contact threshold that connects a residue set.
// ----------------------------------------------------------------------------
// Usage:
//   Residue coordinates are loaded with start; a transfer happens at a clock
//   edge with start high and busy low. Items without last_residue are stored
//   (dropped beyond capacity, setting too_many) and busy stays low. The item
//   with last_residue starts the search and busy rises for its duration.
//   The result appears on chosen_threshold, connected and too_many for one
//   cycle with done high; the receiver cannot stall it.
//   Each threshold tried runs limit setup (states S_WAIT1 and S_WAIT2), a
//   sweep of all N*N ordered pairs through the distance pipeline (coordinate
//   read, absolute differences, squares, compare) plus its drain, and N-1
//   closure passes over the N stored nodes, then one decision. Automatic
//   mode tries up to 9 thresholds; manual mode one. Sets of one node or
//   fewer skip the sweep and closure. The sequencer shares one distance unit.
//   The user writes the manual threshold through cfg_we and cfg_wdata while
//   idle; the block has no guard for this. Reset clears the node count,
//   overflow flag and that register; the coordinate store needs no clearing.
// ----------------------------------------------------------------------------
module contact_threshold_search #(
  parameter int MAX_NODES = cts_pkg::MAX_NODES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [cts_pkg::COORD_W-1:0] x_coord,
  input  wire logic signed [cts_pkg::COORD_W-1:0] y_coord,
  input  wire logic signed [cts_pkg::COORD_W-1:0] z_coord,
  input  wire logic                               last_residue,
  input  wire logic                               cfg_we,
  input  wire logic [cts_pkg::THR_W-1:0]          cfg_wdata,
  output logic                                    done,
  output logic [cts_pkg::THR_W-1:0]               chosen_threshold,
  output logic                                    connected,
  output logic                                    too_many
);
  import cts_pkg::*;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);

  cmd_t             cmd;
  stat_t            stat;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] pair_a, pair_b, close_node;
  logic             load;

  assign load = start && !busy;

  cts_ctrl #(
    .MAX_NODES (MAX_NODES),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .last_residue (last_residue),
    .stat         (stat),
    .count        (count),
    .busy         (busy),
    .cmd          (cmd),
    .pair_a       (pair_a),
    .pair_b       (pair_b),
    .close_node   (close_node)
  );

  cts_datapath #(
    .MAX_NODES (MAX_NODES),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .load             (load),
    .x_coord          (x_coord),
    .y_coord          (y_coord),
    .z_coord          (z_coord),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .cmd              (cmd),
    .pair_a           (pair_a),
    .pair_b           (pair_b),
    .close_node       (close_node),
    .stat             (stat),
    .count            (count),
    .chosen_threshold (chosen_threshold),
    .connected        (connected),
    .too_many         (too_many),
    .done             (done)
  );

endmodule

`default_nettype wire

FILE: test/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for contact_threshold_search.
// A directed table covers coincident residues, exact threshold edges, extreme
// coordinates, overflow and manual thresholds. Random residue sets follow
// under several threshold settings. An internal model of the contact graph
// search predicts results the table leaves open; each done strobe is checked.
// ----------------------------------------------------------------------------
module tb;
  import cts_pkg::*;

  localparam int NODES     = 8;
  localparam int N_ITEMS   = 1850;
  localparam int LIMIT     = 4000000;
  localparam int SETTLE    = 20;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    logic [THR_W-1:0] thr;
    logic             conn;
    logic             tm;
  } outcome_t;

  typedef struct {
    bit               set_cfg;
    logic [THR_W-1:0] cfg;
    coord_t           x, y, z;
    logic             last;
    bit               known;
    outcome_t         res;
  } row_t;

  logic             clk, rst, start, last_residue, cfg_we;
  coord_t           x_coord, y_coord, z_coord;
  logic [THR_W-1:0] cfg_wdata;
  logic             busy, done, connected, too_many;
  logic [THR_W-1:0] chosen_threshold;

  // typed outcome travels with the item, like the payload
  bit               row_known;
  outcome_t         row_res;

  // model state
  coord_t           node_x [NODES];
  coord_t           node_y [NODES];
  coord_t           node_z [NODES];
  int               node_cnt;
  bit               dropped;
  logic [THR_W-1:0] thr_reg;

  outcome_t         pending_q [$];
  row_t             plan [$];
  int               errors;
  int               cycles;
  int               sent;
  bit               gaps_on;

  contact_threshold_search i_dut (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .busy             (busy),
    .x_coord          (x_coord),
    .y_coord          (y_coord),
    .z_coord          (z_coord),
    .last_residue     (last_residue),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .done             (done),
    .chosen_threshold (chosen_threshold),
    .connected        (connected),
    .too_many         (too_many)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic longint unsigned sq(coord_t a, coord_t b);
    longint d;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    return longint'(d) * longint'(d);
  endfunction

  // reachability over contacts at one threshold
  function automatic bit reaches_all(logic [THR_W-1:0] thr);
    longint unsigned lim, d2;
    int unsigned reach, grown, full;
    if (node_cnt <= 1) return 1'b1;
    lim = longint'(thr) * 1000 * longint'(thr) * 1000;
    full = (1 << node_cnt) - 1;
    reach = 1;
    forever begin
      grown = reach;
      for (int i = 0; i < node_cnt; i++) begin
        if (!reach[i]) continue;
        for (int j = 0; j < node_cnt; j++) begin
          d2 = sq(node_x[i], node_x[j]) + sq(node_y[i], node_y[j])
             + sq(node_z[i], node_z[j]);
          if (d2 != 0 && d2 < lim) grown[j] = 1'b1;
        end
      end
      if (grown == reach || grown == full) begin
        reach = grown;
        break;
      end
      reach = grown;
    end
    return reach == full;
  endfunction

  // store one residue; on the last one, work out the search outcome
  function automatic void absorb(coord_t x, coord_t y, coord_t z, logic lst,
                                 output bit fire, output outcome_t o);
    if (node_cnt < NODES) begin
      node_x[node_cnt] = x;
      node_y[node_cnt] = y;
      node_z[node_cnt] = z;
      node_cnt++;
    end else begin
      dropped = 1'b1;
    end
    fire = lst;
    if (!lst) return;
    if (thr_reg != 0) begin
      o.thr  = thr_reg;
      o.conn = reaches_all(thr_reg);
    end else begin
      o.thr  = AUTO_FIRST;
      o.conn = reaches_all(o.thr);
      while (!o.conn && o.thr < AUTO_LAST) begin
        o.thr++;
        o.conn = reaches_all(o.thr);
      end
    end
    o.tm     = dropped;
    node_cnt = 0;
    dropped  = 1'b0;
  endfunction

  // result check and prediction on every accepted transfer
  always @(posedge clk) begin
    bit       fire;
    outcome_t o, e;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else if (!rst) begin
      if (done) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result thr=%0d conn=%0b tm=%0b", $time,
                   chosen_threshold, connected, too_many);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if (chosen_threshold !== e.thr) begin
            $display("%0t: chosen_threshold exp %0d got %0d", $time, e.thr,
                     chosen_threshold);
            errors++;
          end
          if (connected !== e.conn) begin
            $display("%0t: connected exp %0b got %0b", $time, e.conn, connected);
            errors++;
          end
          if (too_many !== e.tm) begin
            $display("%0t: too_many exp %0b got %0b", $time, e.tm, too_many);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        absorb(x_coord, y_coord, z_coord, last_residue, fire, o);
        if (fire) pending_q.insert(pending_q.size(), row_known ? row_res : o);
      end
    end
  end

  task automatic idle_gap();
    while (gaps_on && $urandom_range(99) < 28) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // one transfer; start stays high afterwards
  task automatic send(coord_t x, coord_t y, coord_t z, logic lst, bit known,
                      outcome_t res);
    idle_gap();
    start        <= 1'b1;
    x_coord      <= x;
    y_coord      <= y;
    z_coord      <= z;
    last_residue <= lst;
    row_known    <= known;
    row_res      <= res;
    forever begin
      @(negedge clk);
      if (!busy) break;
      @(posedge clk);
    end
    @(posedge clk);
    sent++;
  endtask

  // let the block drain, then write the threshold register
  task automatic write_thr(logic [THR_W-1:0] v);
    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    thr_reg    = v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_row(bit sc, logic [THR_W-1:0] c, int x, int y, int z,
                         logic lst, bit known, logic [THR_W-1:0] thr,
                         logic conn, logic tm);
    row_t r;
    r.set_cfg  = sc;
    r.cfg      = c;
    r.x        = coord_t'(x);
    r.y        = coord_t'(y);
    r.z        = coord_t'(z);
    r.last     = lst;
    r.known    = known;
    r.res.thr  = thr;
    r.res.conn = conn;
    r.res.tm   = tm;
    plan.insert(plan.size(), r);
  endtask

  function automatic coord_t wild();
    return coord_t'($urandom);
  endfunction

  function automatic coord_t near_origin();
    return coord_t'(int'($urandom_range(2000000)) - 999999);
  endfunction

  function automatic coord_t jitter(coord_t c, int spread);
    return coord_t'(int'(c) + int'($urandom_range(2 * spread)) - spread);
  endfunction

  // random residue set: chains at threshold scale, noise, or duplicates
  task automatic random_set();
    int       n, kind, spread;
    coord_t   x, y, z;
    outcome_t none;
    none = '{default: 0};
    n = ($urandom_range(9) == 0) ? $urandom_range(9, 11) : $urandom_range(1, 8);
    kind   = $urandom_range(9);
    spread = $urandom_range(500, 10000);
    x = ($urandom_range(3) == 0) ? wild() : near_origin();
    y = ($urandom_range(3) == 0) ? wild() : near_origin();
    z = ($urandom_range(3) == 0) ? wild() : near_origin();
    for (int i = 0; i < n; i++) begin
      send(x, y, z, i == n - 1, 1'b0, none);
      if (kind == 0) begin
        x = wild();
        y = wild();
        z = wild();
      end else if (kind != 1 || $urandom_range(1)) begin
        x = jitter(x, spread);
        y = jitter(y, spread);
        z = jitter(z, spread);
      end
    end
  endtask

  initial begin
    outcome_t none;
    none         = '{default: 0};
    errors       = 0;
    cycles       = 0;
    sent         = 0;
    gaps_on      = 1'b1;
    node_cnt     = 0;
    dropped      = 1'b0;
    thr_reg      = '0;
    rst          = 1'b1;
    start        = 1'b0;
    x_coord      = '0;
    y_coord      = '0;
    z_coord      = '0;
    last_residue = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    row_known    = 1'b0;
    row_res      = none;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: single node, coincident pair, exact edge, extremes,
    // overflow, manual extremes
    add_row(1, 0, 0, 0, 0, 1, 1, 7, 1, 0);
    add_row(0, 0, 5, 5, 5, 0, 0, 0, 0, 0);
    add_row(0, 0, 5, 5, 5, 1, 1, 15, 0, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 6999, 0, 0, 1, 1, 7, 1, 0);
    add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 7000, 0, 0, 1, 1, 8, 1, 0);
    add_row(0, 0, -16777216, -16777216, -16777216, 0, 0, 0, 0, 0);
    add_row(0, 0, 16777215, 16777215, 16777215, 1, 1, 15, 0, 0);
    for (int i = 0; i < 9; i++) add_row(0, 0, i * 1000, 0, 0, i == 8, 1, 7, 1, 1);
    add_row(1, 63, 0, 9999999, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 9999999, 62999, 1, 1, 63, 1, 0);
    add_row(1, 1, 0, -999999, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 1000, -999999, 0, 1, 1, 1, 0, 0);
    add_row(0, 0, -999999, 0, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, -999999, 0, 999, 1, 0, 0, 0, 0);
    foreach (plan[i]) begin
      if (plan[i].set_cfg) write_thr(plan[i].cfg);
      send(plan[i].x, plan[i].y, plan[i].z, plan[i].last, plan[i].known,
           plan[i].res);
    end

    // random phases, each under its own threshold setting
    for (int ph = 0; sent < N_ITEMS; ph++) begin
      unique case (ph % 6)
        0, 2:    write_thr('0);
        1:       write_thr(6'd63);
        3:       write_thr(6'd1);
        default: write_thr(THR_W'($urandom_range(1, 63)));
      endcase
      gaps_on = (ph != 2);
      for (int k = 0; k < 150 && sent < N_ITEMS; ) begin
        random_set();
        k = sent % 150 + (sent / 150 > ph ? 150 : 0);
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
src/cts_pkg.sv
src/cts_datapath.sv
src/cts_ctrl.sv
src/contact_threshold_search.sv
test/tb.sv
